// ----- src/dual_bank_segment_scanner_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the dual bank segment scanner
// Shared wrappers around concurrent assertions, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef DUAL_BANK_SEGMENT_SCANNER_TOP_DEFINES_SVH
`define DUAL_BANK_SEGMENT_SCANNER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DBSS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DBSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/dbss_pkg.sv -----
// ----------------------------------------------------------------------------
// Dual bank segment scanner package
// Shared constants, beat layouts, command codes and the glyph table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dbss_pkg;

	// Display geometry.
	localparam int DIGITS   = 5;
	localparam int POS_W    = (DIGITS > 1) ? $clog2(DIGITS) : 1;
	localparam int NUM_W    = 20;
	localparam int NUM_DIG  = 5;
	localparam int BCD_W    = 4 * NUM_DIG;
	localparam int LED_N    = 6;
	localparam int CMD_W    = 3;
	localparam int IN_W     = 40;
	localparam int OUT_W    = 24;

	localparam logic [NUM_W-1:0] NUM_MAX   = 20'd99999;
	localparam logic [7:0]       SEG_BLANK = 8'hFF;
	localparam logic [7:0]       SEG_DP    = 8'h80;
	localparam logic [7:0]       SEL_LED   = 8'hFE;
	localparam logic [7:0]       SEL_OFF   = 8'hFF;
	localparam logic [2:0]       PHASE_LED = 3'd0;
	localparam logic [2:0]       PHASE_OFF = 3'd1;
	localparam logic [2:0]       PHASE_TOP = 3'd6;

	// Command codes; codes 6 and 7 do nothing.
	typedef enum logic [CMD_W-1:0] {
		CMD_SET_DIGIT  = 3'd0,
		CMD_SET_NUMBER = 3'd1,
		CMD_SET_LED    = 3'd2,
		CMD_CLR_DIGITS = 3'd3,
		CMD_CLR_LEDS   = 3'd4,
		CMD_TICK       = 3'd5
	} cmd_t;

	// Input beat fields, last field in the lowest bits.
	typedef struct packed {
		logic        led_on;
		logic [2:0]  led_index;
		logic [19:0] number;
		logic        decimal_point;
		logic [7:0]  digit_value;
		logic [2:0]  digit_position;
		logic        bank;
	} item_t;

	// Output frame, upper byte in the lowest bits.
	typedef struct packed {
		logic [7:0] lower_segments;
		logic [7:0] select_n;
		logic [7:0] upper_segments;
	} frame_t;

	// LED number to stored bit.
	localparam logic [2:0] LED_PERM [LED_N] = '{3'd3, 3'd5, 3'd1, 3'd0, 3'd2, 3'd4};

	// Hex glyphs, active low; anything above 15 is blank.
	function automatic logic [7:0] glyph(input logic [7:0] v);
		logic [7:0] g;
		begin
			unique case (v)
				8'd0:    g = 8'hC0;
				8'd1:    g = 8'hF9;
				8'd2:    g = 8'hA4;
				8'd3:    g = 8'hB0;
				8'd4:    g = 8'h99;
				8'd5:    g = 8'h92;
				8'd6:    g = 8'h82;
				8'd7:    g = 8'hF8;
				8'd8:    g = 8'h80;
				8'd9:    g = 8'h90;
				8'd10:   g = 8'h88;
				8'd11:   g = 8'h83;
				8'd12:   g = 8'hC6;
				8'd13:   g = 8'hA1;
				8'd14:   g = 8'h86;
				8'd15:   g = 8'h8E;
				default: g = SEG_BLANK;
			endcase
			return g;
		end
	endfunction

endpackage

`default_nettype wire

// ----- src/dbss_bcd.sv -----
// ----------------------------------------------------------------------------
// Iterative binary to BCD converter
// Shift-and-add-three over one input bit per cycle, a nibble adjust per digit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dbss_bcd (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [dbss_pkg::NUM_W-1:0] value,
	output logic                           done,
	output logic [dbss_pkg::BCD_W-1:0]     bcd
);
	import dbss_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] bin_q;
	logic [BCD_W-1:0] bcd_q;
	logic [BCD_W-1:0] adj;

	// Add three to every decimal digit that has reached five.
	always_comb begin
		for (int i = 0; i < NUM_DIG; i++) begin
			adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
				: bcd_q[4*i +: 4];
		end
	end

	// Control: count one step per input bit, pulse done after the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift the adjusted digits and the binary value left together.
	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (busy_q) begin
			{bcd_q, bin_q} <= {adj[BCD_W-2:0], bin_q, 1'b0};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

`default_nettype wire

// ----- src/dual_bank_segment_scanner_top.sv -----
// ----------------------------------------------------------------------------
// Dual bank segment scanner
// Two banks of segment bytes and six LEDs, one or two frames per refresh tick.
// ----------------------------------------------------------------------------
// Usage: commands arrive as beats on the s_ channel, the command code in
// s_tuser and its operands in s_tdata. Digit, LED and clear commands are
// applied on acceptance and leave the sequencer idle. Set number saturates
// the value at 99999 and converts it in the BCD unit, one bit per cycle; no
// further beat is taken until the conversion is done. A refresh tick
// advances the scan phase and yields one or two frames on the m_ channel,
// each frame holding the upper byte, the select byte and the lower byte for
// the shift register chain; m_tlast marks the final frame of the tick. The
// first frame is registered in the emit state that follows acceptance of
// the tick, once the output register is free; phase one adds an all-off
// frame before the LED frame. s_tready is high only while the sequencer is
// idle. If the receiver stalls, the frame is held; while a frame of the
// tick is still to be registered, the sequencer waits and takes no command.
// Reset blanks both banks, clears the LEDs and sets the scan phase to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "dual_bank_segment_scanner_top_defines.svh"

module dual_bank_segment_scanner_top (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	// bank, digit_position, digit_value, decimal_point, number, led_index, led_on
	input  wire logic [dbss_pkg::IN_W-1:0]  s_tdata,
	// command
	input  wire logic [dbss_pkg::CMD_W-1:0] s_tuser,
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	// upper_segments, select_n, lower_segments
	output logic [dbss_pkg::OUT_W-1:0]     m_tdata,
	output logic                           m_tlast
);
	import dbss_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_CONV   = 4'b0010,
		ST_EMIT_A = 4'b0100,
		ST_EMIT_B = 4'b1000
	} state_t;

	state_t           state_q;
	logic [7:0]       upper_q [DIGITS];
	logic [7:0]       lower_q [DIGITS];
	logic [LED_N-1:0] led_q;
	logic [2:0]       phase_q;
	logic             bank_q;
	logic             m_tvalid_q;
	frame_t           frame_q;
	logic             last_q;

	item_t            item;
	cmd_t             cmd;
	logic             accept;
	logic             out_free;
	logic [NUM_W-1:0] num_sat;
	logic             bcd_done;
	logic [BCD_W-1:0] bcd;
	logic [7:0]       code;
	frame_t           frame;
	logic             frame_last;
	logic [2:0]       scan_pos;

	assign item     = item_t'(s_tdata[$bits(item_t)-1:0]);
	assign cmd      = cmd_t'(s_tuser);
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign num_sat  = (item.number > NUM_MAX) ? NUM_MAX : item.number;

	// Stored byte for a single digit write, decimal point clears bit 7.
	always_comb begin
		code = glyph(item.digit_value);
		if (item.decimal_point) begin
			code = code & ~SEG_DP;
		end
	end

	dbss_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && (cmd == CMD_SET_NUMBER)),
		.value  (num_sat),
		.done   (bcd_done),
		.bcd    (bcd)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (cmd == CMD_SET_NUMBER)) begin
						state_q <= ST_CONV;
					end else if (accept && (cmd == CMD_TICK)) begin
						state_q <= ST_EMIT_A;
					end
				end
				ST_CONV: begin
					if (bcd_done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT_A: begin
					if (out_free) begin
						state_q <= (phase_q == PHASE_OFF) ? ST_EMIT_B : ST_IDLE;
					end
				end
				ST_EMIT_B: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Display state: digit banks, LED bits and scan phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGITS; i++) begin
				upper_q[i] <= SEG_BLANK;
				lower_q[i] <= SEG_BLANK;
			end
			led_q   <= '0;
			phase_q <= PHASE_LED;
		end else begin
			if (accept) begin
				unique case (cmd)
					CMD_SET_DIGIT: begin
						if (32'(item.digit_position) < DIGITS) begin
							if (item.bank) begin
								upper_q[item.digit_position[POS_W-1:0]] <= code;
							end else begin
								lower_q[item.digit_position[POS_W-1:0]] <= code;
							end
						end
					end
					CMD_SET_LED: begin
						if (32'(item.led_index) < LED_N) begin
							led_q[LED_PERM[item.led_index]] <= item.led_on;
						end
					end
					CMD_CLR_DIGITS: begin
						for (int i = 0; i < DIGITS; i++) begin
							upper_q[i] <= SEG_BLANK;
							lower_q[i] <= SEG_BLANK;
						end
					end
					CMD_CLR_LEDS: begin
						led_q <= '0;
					end
					CMD_TICK: begin
						phase_q <= (phase_q == PHASE_TOP) ? PHASE_LED : phase_q + 3'd1;
					end
					default: ;
				endcase
			end
			// Converted number lands in positions from the ten-thousands down.
			if (bcd_done) begin
				for (int p = 0; p < DIGITS; p++) begin
					if (bank_q) begin
						upper_q[p] <= glyph({4'd0, bcd[4*(NUM_DIG-1-p) +: 4]});
					end else begin
						lower_q[p] <= glyph({4'd0, bcd[4*(NUM_DIG-1-p) +: 4]});
					end
				end
			end
		end
	end

	// Bank of a pending number write.
	always_ff @(posedge clk) begin
		if (accept) begin
			bank_q <= item.bank;
		end
	end

	// Frame for the current phase.
	assign scan_pos = PHASE_TOP - phase_q;

	always_comb begin
		frame_last = 1'b1;
		if (phase_q == PHASE_LED || state_q == ST_EMIT_B) begin
			frame.upper_segments = SEG_BLANK;
			frame.select_n       = SEL_LED;
			frame.lower_segments = {2'b00, led_q};
		end else if (phase_q == PHASE_OFF) begin
			frame.upper_segments = SEG_BLANK;
			frame.select_n       = SEL_OFF;
			frame.lower_segments = SEG_BLANK;
			frame_last           = 1'b0;
		end else begin
			frame.select_n       = ~(8'd1 << phase_q);
			frame.upper_segments = SEG_BLANK;
			frame.lower_segments = SEG_BLANK;
			if (32'(scan_pos) < DIGITS) begin
				frame.upper_segments = upper_q[scan_pos[POS_W-1:0]];
				frame.lower_segments = lower_q[scan_pos[POS_W-1:0]];
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_free && (state_q == ST_EMIT_A || state_q == ST_EMIT_B)) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && (state_q == ST_EMIT_A || state_q == ST_EMIT_B)) begin
			frame_q <= frame;
			last_q  <= frame_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = frame_q;
	assign m_tlast  = last_q;

	// Checks on the sequencer.
	`DBSS_ASSERT_SAME(a_emit_b_phase, clk, arst_n, state_q == ST_EMIT_B,
		phase_q == PHASE_OFF, "second frame outside phase one")
	`DBSS_ASSERT_SAME(a_done_in_conv, clk, arst_n, bcd_done, state_q == ST_CONV,
		"conversion finished while not converting")
	`DBSS_ASSERT_NEXT(a_tick_emits, clk, arst_n, accept && cmd == CMD_TICK,
		state_q == ST_EMIT_A, "tick did not start a frame")
	`DBSS_ASSERT_SAME(a_notlast_off, clk, arst_n, m_tvalid && !m_tlast,
		phase_q == PHASE_OFF && m_tdata == {OUT_W{1'b1}}, "non-final frame is not all-off")

endmodule

`default_nettype wire
